/* hw/rtl/sh64_pkg.sv */
package sh64_pkg;

	// hash constants
	localparam logic [63:0] HashM    = 64'h880355f21e6d1965;
	localparam logic [63:0] HashSeed = 64'h243F6A8885A308D3;
	localparam logic [63:0] MixMul   = 64'h2127599bf4325c37;
	localparam int unsigned MixSh1   = 23;
	localparam int unsigned MixSh2   = 47;

	// one classified chunk, passed from front to back
	typedef struct packed {
		logic [63:0] mixed;
		logic        has_data;
		logic        first;
		logic        last;
		logic [31:0] len;
	} chunk_t;

	// multiplier request and response
	typedef struct packed {
		logic        start;
		logic [63:0] a;
		logic [63:0] b;
	} mul_req_t;

	typedef struct packed {
		logic        done;
		logic [63:0] product;
	} mul_rsp_t;

	typedef enum logic [1:0] {
		F_IDLE,
		F_MUL,
		F_PUSH
	} front_state_t;

	typedef enum logic [2:0] {
		B_IDLE,
		B_SEED,
		B_ABSORB,
		B_FIN,
		B_OUT
	} back_state_t;

	// first half of the mix, ahead of the multiply
	function automatic logic [63:0] mix_pre(input logic [63:0] x);
		return x ^ (x >> MixSh1);
	endfunction

	// second half of the mix, after the multiply
	function automatic logic [63:0] mix_post(input logic [63:0] x);
		return x ^ (x >> MixSh2);
	endfunction

endpackage

/* hw/rtl/sh64_mul.sv */
module sh64_mul import sh64_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  mul_req_t req,
	output mul_rsp_t rsp
);

	logic [63:0] a_q;
	logic [63:0] b_q;
	logic [63:0] prod_q;
	logic [63:0] sum_q;
	logic [1:0]  step_q;
	logic        busy_q;
	logic [31:0] a_sel;
	logic [31:0] b_sel;
	logic [63:0] prod_d;

	// pick the 32-bit halves for this step; the high-by-high term falls off the top
	always_comb begin
		case (step_q)
			2'd0: begin
				a_sel = a_q[31:0];
				b_sel = b_q[31:0];
			end
			2'd1: begin
				a_sel = a_q[31:0];
				b_sel = b_q[63:32];
			end
			2'd2: begin
				a_sel = a_q[63:32];
				b_sel = b_q[31:0];
			end
			default: begin
				a_sel = 32'd0;
				b_sel = 32'd0;
			end
		endcase
	end

	assign prod_d = {32'd0, a_sel} * {32'd0, b_sel};

	// step counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			step_q <= 2'd0;
		end else if (req.start) begin
			busy_q <= 1'b1;
			step_q <= 2'd0;
		end else if (busy_q) begin
			if (step_q == 2'd3) begin
				busy_q <= 1'b0;
			end
			step_q <= step_q + 2'd1;
		end
	end

	// operands, partial product and running sum
	always_ff @(posedge clk) begin
		if (req.start) begin
			a_q <= req.a;
			b_q <= req.b;
		end
		prod_q <= prod_d;
		if (step_q == 2'd1) begin
			sum_q <= prod_q;
		end else if (step_q == 2'd2) begin
			sum_q <= sum_q + {prod_q[31:0], 32'd0};
		end
	end

	assign rsp.done    = busy_q && (step_q == 2'd3);
	assign rsp.product = sum_q + {prod_q[31:0], 32'd0};

endmodule

/* hw/rtl/sh64_front.sv */
module sh64_front import sh64_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        push,
	output logic        full,
	input  logic [63:0] data_word,
	input  logic [3:0]  byte_count,
	input  logic        first_chunk,
	input  logic        last_chunk,
	input  logic [31:0] total_length,
	output logic        q_push,
	output chunk_t      q_entry,
	input  logic        q_full
);

	front_state_t state_q;
	front_state_t state_d;
	mul_req_t     mul_req;
	mul_rsp_t     mul_rsp;
	logic [63:0]  masked;
	logic         accept;
	logic [63:0]  mixed_q;
	logic         has_data_q;
	logic         first_q;
	logic         last_q;
	logic [31:0]  len_q;

	// keep only the valid low bytes; counts above eight keep the whole word
	always_comb begin
		for (int i = 0; i < 8; i++) begin
			masked[8*i +: 8] = (4'(i) < byte_count) ? data_word[8*i +: 8] : 8'h00;
		end
	end

	assign accept = push && !full;

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			F_IDLE: begin
				if (accept) begin
					state_d = F_MUL;
				end
			end
			F_MUL: begin
				if (mul_rsp.done) begin
					state_d = F_PUSH;
				end
			end
			F_PUSH: begin
				if (!q_full) begin
					state_d = F_IDLE;
				end
			end
			default: state_d = F_IDLE;
		endcase
	end

	// outputs
	always_comb begin
		full          = (state_q != F_IDLE);
		q_push        = (state_q == F_PUSH) && !q_full;
		mul_req.start = accept;
		mul_req.a     = mix_pre(masked);
		mul_req.b     = MixMul;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= F_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// request fields and mixed word
	always_ff @(posedge clk) begin
		if (accept) begin
			has_data_q <= (byte_count != 4'd0);
			first_q    <= first_chunk;
			last_q     <= last_chunk;
			len_q      <= total_length;
		end
		if (mul_rsp.done) begin
			mixed_q <= mix_post(mul_rsp.product);
		end
	end

	assign q_entry.mixed    = mixed_q;
	assign q_entry.has_data = has_data_q;
	assign q_entry.first    = first_q;
	assign q_entry.last     = last_q;
	assign q_entry.len      = len_q;

	sh64_mul u_mul (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (mul_req),
		.rsp    (mul_rsp)
	);

endmodule

/* hw/rtl/sh64_queue.sv */
module sh64_queue import sh64_pkg::*; (
	input  logic   clk,
	input  logic   arst_n,
	input  logic   push,
	input  chunk_t push_entry,
	output logic   full,
	input  logic   pop,
	output logic   empty,
	output chunk_t head
);

	chunk_t     slots_q [2];
	logic       wr_q;
	logic       rd_q;
	logic [1:0] count_q;
	logic       do_push;
	logic       do_pop;

	assign full    = (count_q == 2'd2);
	assign empty   = (count_q == 2'd0);
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;
	assign head    = slots_q[rd_q];

	// pointers and fill level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q    <= 1'b0;
			rd_q    <= 1'b0;
			count_q <= 2'd0;
		end else begin
			if (do_push) begin
				wr_q <= !wr_q;
			end
			if (do_pop) begin
				rd_q <= !rd_q;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 2'd1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 2'd1;
			end
		end
	end

	// storage
	always_ff @(posedge clk) begin
		if (do_push) begin
			slots_q[wr_q] <= push_entry;
		end
	end

endmodule

/* hw/rtl/sh64_back.sv */
module sh64_back import sh64_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        q_empty,
	input  chunk_t      q_head,
	output logic        q_pop,
	output logic [63:0] hash_value,
	output logic        empty,
	input  logic        pop
);

	back_state_t state_q;
	back_state_t state_d;
	mul_req_t    mul_req;
	mul_rsp_t    mul_rsp;
	chunk_t      ent_q;
	logic [63:0] acc_q;
	logic [63:0] res_q;
	logic [63:0] out_q;
	logic        out_valid_q;
	logic [63:0] seed_acc;
	logic        out_free;
	logic        out_load;

	assign seed_acc = HashSeed ^ mul_rsp.product;
	assign out_free = !out_valid_q || pop;
	assign out_load = (state_q == B_OUT) && out_free;

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			B_IDLE: begin
				if (!q_empty) begin
					if (q_head.first) begin
						state_d = B_SEED;
					end else if (q_head.has_data) begin
						state_d = B_ABSORB;
					end else if (q_head.last) begin
						state_d = B_FIN;
					end
				end
			end
			B_SEED: begin
				if (mul_rsp.done) begin
					if (ent_q.has_data) begin
						state_d = B_ABSORB;
					end else if (ent_q.last) begin
						state_d = B_FIN;
					end else begin
						state_d = B_IDLE;
					end
				end
			end
			B_ABSORB: begin
				if (mul_rsp.done) begin
					state_d = ent_q.last ? B_FIN : B_IDLE;
				end
			end
			B_FIN: begin
				if (mul_rsp.done) begin
					state_d = B_OUT;
				end
			end
			B_OUT: begin
				if (out_free) begin
					state_d = B_IDLE;
				end
			end
			default: state_d = B_IDLE;
		endcase
	end

	// outputs: queue pop and multiplier requests
	always_comb begin
		q_pop         = 1'b0;
		mul_req.start = 1'b0;
		mul_req.a     = acc_q;
		mul_req.b     = HashM;
		case (state_q)
			B_IDLE: begin
				if (!q_empty) begin
					q_pop = 1'b1;
					if (q_head.first) begin
						mul_req.start = 1'b1;
						mul_req.a     = {32'd0, q_head.len};
					end else if (q_head.has_data) begin
						mul_req.start = 1'b1;
						mul_req.a     = acc_q ^ q_head.mixed;
					end else if (q_head.last) begin
						mul_req.start = 1'b1;
						mul_req.a     = mix_pre(acc_q);
						mul_req.b     = MixMul;
					end
				end
			end
			B_SEED: begin
				if (mul_rsp.done) begin
					if (ent_q.has_data) begin
						mul_req.start = 1'b1;
						mul_req.a     = seed_acc ^ ent_q.mixed;
					end else if (ent_q.last) begin
						mul_req.start = 1'b1;
						mul_req.a     = mix_pre(seed_acc);
						mul_req.b     = MixMul;
					end
				end
			end
			B_ABSORB: begin
				if (mul_rsp.done && ent_q.last) begin
					mul_req.start = 1'b1;
					mul_req.a     = mix_pre(mul_rsp.product);
					mul_req.b     = MixMul;
				end
			end
			default: begin
			end
		endcase
	end

	// control state and accumulator
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= B_IDLE;
			acc_q       <= 64'd0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == B_SEED && mul_rsp.done) begin
				acc_q <= seed_acc;
			end else if (state_q == B_ABSORB && mul_rsp.done) begin
				acc_q <= mul_rsp.product;
			end
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (pop) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// request held in the back, finished hash and output register
	always_ff @(posedge clk) begin
		if (q_pop) begin
			ent_q <= q_head;
		end
		if (state_q == B_FIN && mul_rsp.done) begin
			res_q <= mix_post(mul_rsp.product);
		end
		if (out_load) begin
			out_q <= res_q;
		end
	end

	assign hash_value = out_q;
	assign empty      = !out_valid_q;

	sh64_mul u_mul (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (mul_req),
		.rsp    (mul_rsp)
	);

endmodule

/* hw/rtl/string_hash_64.sv */
// channel  | handshake        | payload
// ---------+------------------+--------------------------------------------------
// input    | push / full      | data_word, byte_count, first_chunk, last_chunk,
//          |                  | total_length
// result   | empty / pop      | hash_value
//
// the front takes a request, then stays full while its own 32x32 multiplier does
// the word mix and until it has handed the chunk over to the queue
// the back pops each data chunk and absorbs it with one multiply, with a seed
// multiply ahead of it on a first chunk and the final mix multiply and output
// after it on a last chunk; a two-deep queue between front and back and the
// output register let either side stall on its own; after reset the accumulator
// is zero and both sides idle
module string_hash_64 import sh64_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        push,
	output logic        full,
	input  logic [63:0] data_word,
	input  logic [3:0]  byte_count,
	input  logic        first_chunk,
	input  logic        last_chunk,
	input  logic [31:0] total_length,
	output logic        empty,
	input  logic        pop,
	output logic [63:0] hash_value
);

	chunk_t fq_entry;
	chunk_t bq_head;
	logic   fq_push;
	logic   fq_full;
	logic   bq_pop;
	logic   bq_empty;

	// classify and pre-mix each chunk
	sh64_front u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.push         (push),
		.full         (full),
		.data_word    (data_word),
		.byte_count   (byte_count),
		.first_chunk  (first_chunk),
		.last_chunk   (last_chunk),
		.total_length (total_length),
		.q_push       (fq_push),
		.q_entry      (fq_entry),
		.q_full       (fq_full)
	);

	// decoupling queue
	sh64_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (fq_push),
		.push_entry (fq_entry),
		.full       (fq_full),
		.pop        (bq_pop),
		.empty      (bq_empty),
		.head       (bq_head)
	);

	// accumulator, final mix and result register
	sh64_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.q_empty    (bq_empty),
		.q_head     (bq_head),
		.q_pop      (bq_pop),
		.hash_value (hash_value),
		.empty      (empty),
		.pop        (pop)
	);

endmodule

/* hw/rtl/sh64_check.sv */
module sh64_check (
	input logic        clk,
	input logic        arst_n,
	input logic        push,
	input logic        full,
	input logic        pop,
	input logic        empty,
	input logic [63:0] hash_value
);

	// a waiting result holds until taken
	assert property (@(posedge clk) disable iff (!arst_n)
		!empty && !pop |=> !empty && $stable(hash_value))
		else $error("result changed or vanished while not taken");

	// an accepted request keeps the front busy through its multiply
	assert property (@(posedge clk) disable iff (!arst_n)
		push && !full |=> full ##1 full ##1 full ##1 full)
		else $error("front took a new request during the word mix");

	// handshake outputs always defined, and a waiting result fully defined
	assert property (@(posedge clk) disable iff (!arst_n)
		!$isunknown({full, empty}) && (empty || !$isunknown(hash_value)))
		else $error("unknown value on a handshake or a waiting result");

endmodule

bind string_hash_64 sh64_check u_check (.*);
